>>> src/sm_pkg.sv
package sm_pkg;

    // Opcodes carried in the command field
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_NEG  = 3'd5;
    localparam logic [2:0] OP_RET  = 3'd6;

    // Status codes reported with each result
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RET   = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;

    // Q16.16 limits
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // Request from the sequencer to the multiply/divide unit
    typedef struct packed {
        logic start;
        logic op_div;
    } md_req_t;

    // Clamp a 33-bit signed sum to the 32-bit range
    function automatic logic [31:0] sat33(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31])
        begin
            r = s[32] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/sm_cmd_if.sv
interface sm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic signed [31:0] constant_value;

    modport source (output valid, output command, output constant_value, input ready);
    modport sink (input valid, input command, input constant_value, output ready);
endinterface

>>> src/sm_res_if.sv
interface sm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [31:0] result_value;
    logic [4:0]  stack_depth;

    modport source (output valid, output status, output result_value, output stack_depth,
                    input ready);
    modport sink (input valid, input status, input result_value, input stack_depth,
                  output ready);
endinterface

>>> src/sm_ram.sv
module sm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sm_muldiv.sv
module sm_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  sm_pkg::md_req_t   req,
    input  logic [31:0]       op_a,
    input  logic [31:0]       op_b,
    output logic              done,
    output logic [31:0]       result
);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_SAT
    } md_state_t;

    md_state_t   state_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        div_reg;
    logic [31:0] opnd_reg;
    logic [63:0] prod_reg;
    logic [47:0] quo_reg;
    logic [31:0] rem_reg;
    logic        done_reg;
    logic [31:0] result_reg;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] mul_sum;
    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic        rem_ge;
    logic [47:0] mag_q;
    logic [31:0] sat_q;

    // Operand magnitudes
    assign mag_a = op_a[31] ? (~op_a + 32'd1) : op_a;
    assign mag_b = op_b[31] ? (~op_b + 32'd1) : op_b;

    // One multiplier bit per cycle: add, then shift right
    assign mul_sum = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, opnd_reg} : 33'd0);

    // One quotient bit per cycle: shift in, trial subtract
    assign rem_sh   = {rem_reg, quo_reg[47]};
    assign rem_ge   = rem_sh >= {1'b0, opnd_reg};
    assign rem_diff = rem_sh - {1'b0, opnd_reg};

    // Apply sign and clamp the magnitude
    always_comb
    begin
        mag_q = div_reg ? quo_reg : prod_reg[63:16];
        if (neg_reg)
        begin
            if ((|mag_q[47:32]) || (mag_q[31] && (|mag_q[30:0])))
            begin
                sat_q = sm_pkg::Q_MIN;
            end
            else
            begin
                sat_q = ~mag_q[31:0] + 32'd1;
            end
        end
        else
        begin
            if (|mag_q[47:31])
            begin
                sat_q = sm_pkg::Q_MAX;
            end
            else
            begin
                sat_q = mag_q[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // Pulse done for one cycle as the result is latched
            done_reg <= (state_reg == MD_SAT);
            case (state_reg)
                MD_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg  <= op_a[31] ^ op_b[31];
                        div_reg  <= req.op_div;
                        opnd_reg <= req.op_div ? mag_b : mag_a;
                        prod_reg <= {32'd0, mag_b};
                        quo_reg  <= {mag_a, 16'd0};
                        rem_reg  <= '0;
                        if (req.op_div)
                        begin
                            cnt_reg   <= 6'd47;
                            state_reg <= MD_DIV;
                        end
                        else
                        begin
                            cnt_reg   <= 6'd31;
                            state_reg <= MD_MUL;
                        end
                    end
                end
                MD_MUL:
                begin
                    prod_reg <= {mul_sum, prod_reg[31:1]};
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= MD_SAT;
                    end
                end
                MD_DIV:
                begin
                    rem_reg <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
                    quo_reg <= {quo_reg[46:0], rem_ge};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= MD_SAT;
                    end
                end
                MD_SAT:
                begin
                    result_reg <= sat_q;
                    state_reg  <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/stack_machine_arith_executor.sv
// Push, negate, unused opcodes and faults go from execute straight to emit; add, subtract and a
// return that leaves values on the stack also pass through a RAM read state; multiply and divide
// then wait on the bit-serial shift-add and restoring-divide loops in the multiply/divide unit.
// One instruction at a time; the next beat is taken once the result is queued.
// Reset clears the stack level (empty stack), the sequencer state and the result valid; stack RAM is not cleared.
module stack_machine_arith_executor #(
    parameter int STACK_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sm_cmd_if.sink     cmd,
    sm_res_if.source   res
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_WAIT,
        S_POPRD,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [2:0]         cmd_reg;
    logic [31:0]        k_reg;
    logic [LVL_W-1:0]   level_reg;
    logic [31:0]        top_reg;
    logic [2:0]         status_reg;
    logic               ret_reg;
    logic [31:0]        ret_val_reg;
    logic               res_valid_reg;
    logic [2:0]         res_status_reg;
    logic [31:0]        res_value_reg;
    logic [4:0]         res_depth_reg;

    state_t             exec_next;
    logic [LVL_W-1:0]   level_m1;
    logic [LVL_W-1:0]   level_m2;
    logic               lvl_full;
    logic               lvl_ne0;
    logic               lvl_ge2;
    logic               is_binary;
    logic               is_addsub;
    logic               div_zero;
    logic [31:0]        addsub_val;
    logic [31:0]        neg_val;
    logic [31:0]        emit_value;
    logic [LVL_W+4:0]   depth_wide;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [31:0]        wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [31:0]        rd_data;

    sm_pkg::md_req_t    md_req;
    logic               md_done;
    logic [31:0]        md_result;

    sm_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sm_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .op_a   (rd_data),
        .op_b   (top_reg),
        .done   (md_done),
        .result (md_result)
    );

    // Stack level decode
    assign level_m1  = level_reg - LVL_W'(1);
    assign level_m2  = level_reg - LVL_W'(2);
    assign lvl_full  = level_reg == LVL_W'(STACK_DEPTH);
    assign lvl_ne0   = level_reg != '0;
    assign lvl_ge2   = level_reg >= LVL_W'(2);
    assign is_binary = (cmd_reg == sm_pkg::OP_ADD) || (cmd_reg == sm_pkg::OP_SUB) ||
                       (cmd_reg == sm_pkg::OP_MUL) || (cmd_reg == sm_pkg::OP_DIV);
    assign is_addsub = (cmd_reg == sm_pkg::OP_ADD) || (cmd_reg == sm_pkg::OP_SUB);
    assign div_zero  = (cmd_reg == sm_pkg::OP_DIV) && (top_reg == 32'd0);

    // Left operand from RAM, right operand is the cached top
    assign addsub_val = (cmd_reg == sm_pkg::OP_SUB)
        ? sm_pkg::sat33({rd_data[31], rd_data} - {top_reg[31], top_reg})
        : sm_pkg::sat33({rd_data[31], rd_data} + {top_reg[31], top_reg});
    assign neg_val = (top_reg == sm_pkg::Q_MIN) ? sm_pkg::Q_MAX : (~top_reg + 32'd1);

    assign emit_value = ret_reg ? ret_val_reg : (lvl_ne0 ? top_reg : 32'd0);
    assign depth_wide = {5'd0, level_reg};

    // Kick the multiply/divide unit once the left operand is read
    assign md_req.start  = (state_reg == S_READ) && !is_addsub;
    assign md_req.op_div = cmd_reg == sm_pkg::OP_DIV;

    // Pick where an executing instruction goes next
    always_comb
    begin
        exec_next = S_EMIT;
        if (is_binary && lvl_ge2 && !div_zero)
        begin
            exec_next = S_READ;
        end
        else if ((cmd_reg == sm_pkg::OP_RET) && lvl_ge2)
        begin
            exec_next = S_POPRD;
        end
    end

    // Stack RAM accesses
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            S_EXEC:
            begin
                if (cmd_reg == sm_pkg::OP_PUSH)
                begin
                    wr_en   = !lvl_full;
                    wr_addr = level_reg[ADDR_W-1:0];
                    wr_data = k_reg;
                end
                else if (is_binary)
                begin
                    rd_en   = lvl_ge2 && !div_zero;
                    rd_addr = level_m2[ADDR_W-1:0];
                end
                else if (cmd_reg == sm_pkg::OP_NEG)
                begin
                    wr_en   = lvl_ne0;
                    wr_addr = level_m1[ADDR_W-1:0];
                    wr_data = neg_val;
                end
                else if (cmd_reg == sm_pkg::OP_RET)
                begin
                    rd_en   = lvl_ge2;
                    rd_addr = level_m2[ADDR_W-1:0];
                end
            end
            S_READ:
            begin
                wr_en   = is_addsub;
                wr_addr = level_m2[ADDR_W-1:0];
                wr_data = addsub_val;
            end
            S_WAIT:
            begin
                wr_en   = md_done;
                wr_addr = level_m2[ADDR_W-1:0];
                wr_data = md_result;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            ret_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the output beat once taken, unless a new one replaces it
            if (res_valid_reg && res.ready && (state_reg != S_EMIT))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg    <= cmd.command;
                        k_reg      <= cmd.constant_value;
                        ret_reg    <= 1'b0;
                        status_reg <= sm_pkg::ST_OK;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= exec_next;
                    if (cmd_reg == sm_pkg::OP_PUSH)
                    begin
                        if (lvl_full)
                        begin
                            status_reg <= sm_pkg::ST_OVER;
                        end
                        else
                        begin
                            top_reg   <= k_reg;
                            level_reg <= level_reg + LVL_W'(1);
                        end
                    end
                    else if (is_binary)
                    begin
                        if (!lvl_ge2)
                        begin
                            status_reg <= sm_pkg::ST_UNDER;
                        end
                        else if (div_zero)
                        begin
                            status_reg <= sm_pkg::ST_DIV0;
                        end
                    end
                    else if (cmd_reg == sm_pkg::OP_NEG)
                    begin
                        if (lvl_ne0)
                        begin
                            top_reg <= neg_val;
                        end
                        else
                        begin
                            status_reg <= sm_pkg::ST_UNDER;
                        end
                    end
                    else if (cmd_reg == sm_pkg::OP_RET)
                    begin
                        if (lvl_ne0)
                        begin
                            status_reg  <= sm_pkg::ST_RET;
                            ret_reg     <= 1'b1;
                            ret_val_reg <= top_reg;
                            level_reg   <= level_m1;
                        end
                        else
                        begin
                            status_reg <= sm_pkg::ST_UNDER;
                        end
                    end
                end
                S_READ:
                begin
                    if (is_addsub)
                    begin
                        top_reg   <= addsub_val;
                        level_reg <= level_m1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (md_done)
                    begin
                        top_reg   <= md_result;
                        level_reg <= level_m1;
                        state_reg <= S_EMIT;
                    end
                end
                S_POPRD:
                begin
                    top_reg   <= rd_data;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // Hold until the output register is free
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= status_reg;
                        res_value_reg  <= emit_value;
                        res_depth_reg  <= depth_wide[4:0];
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready        = state_reg == S_IDLE;
    assign res.valid        = res_valid_reg;
    assign res.status       = res_status_reg;
    assign res.result_value = res_value_reg;
    assign res.stack_depth  = res_depth_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    // Command code that the block decodes as a no-op
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int STACK_SLOTS    = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;

    localparam longint QL_MAX = longint'(2147483647);
    localparam longint QL_MIN = -longint'(2147483647) - 1;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [4:0]  depth;
    } vm_result_t;

    logic clk;
    logic rst_n;

    sm_cmd_if cmd_ch();
    sm_res_if res_ch();

    stack_machine_arith_executor #(
        .STACK_DEPTH(STACK_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch),
        .res(res_ch)
    );

    // Shadow of the operand stack and the results still owed by the block
    logic [31:0] shadow_stack[STACK_SLOTS];
    int          shadow_fill;
    vm_result_t  owed_results[$];

    int error_count;
    int idle_cycles;
    int send_calm;
    int recv_calm;
    bit hold_results;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Clamp a wide signed value to Q16.16
    function automatic logic [31:0] clamp_q(longint v);
        if (v > QL_MAX)
        begin
            return sm_pkg::Q_MAX;
        end
        if (v < QL_MIN)
        begin
            return sm_pkg::Q_MIN;
        end
        return v[31:0];
    endfunction

    // Execute one instruction on the shadow stack and return what the block must report
    function automatic vm_result_t execute_instr(logic [2:0] op, logic [31:0] k);
        vm_result_t r;
        longint     lhs;
        longint     rhs;
        logic [31:0] v;
        bit         popped;
        r.status = sm_pkg::ST_OK;
        r.value  = '0;
        popped   = 1'b0;
        case (op)
            sm_pkg::OP_PUSH:
            begin
                if (shadow_fill >= STACK_SLOTS)
                begin
                    r.status = sm_pkg::ST_OVER;
                end
                else
                begin
                    shadow_stack[shadow_fill] = k;
                    shadow_fill++;
                end
            end
            sm_pkg::OP_ADD, sm_pkg::OP_SUB, sm_pkg::OP_MUL, sm_pkg::OP_DIV:
            begin
                if (shadow_fill < 2)
                begin
                    r.status = sm_pkg::ST_UNDER;
                end
                else
                begin
                    lhs = longint'($signed(shadow_stack[shadow_fill - 2]));
                    rhs = longint'($signed(shadow_stack[shadow_fill - 1]));
                    if (op == sm_pkg::OP_DIV && rhs == 0)
                    begin
                        r.status = sm_pkg::ST_DIV0;
                    end
                    else
                    begin
                        // Integer division truncates toward zero, as the block rounds
                        case (op)
                            sm_pkg::OP_ADD: v = clamp_q(lhs + rhs);
                            sm_pkg::OP_SUB: v = clamp_q(lhs - rhs);
                            sm_pkg::OP_MUL: v = clamp_q((lhs * rhs) / 65536);
                            default:        v = clamp_q((lhs * 65536) / rhs);
                        endcase
                        shadow_fill--;
                        shadow_stack[shadow_fill - 1] = v;
                    end
                end
            end
            sm_pkg::OP_NEG:
            begin
                if (shadow_fill < 1)
                begin
                    r.status = sm_pkg::ST_UNDER;
                end
                else
                begin
                    lhs = longint'($signed(shadow_stack[shadow_fill - 1]));
                    shadow_stack[shadow_fill - 1] = clamp_q(-lhs);
                end
            end
            sm_pkg::OP_RET:
            begin
                if (shadow_fill < 1)
                begin
                    r.status = sm_pkg::ST_UNDER;
                end
                else
                begin
                    shadow_fill--;
                    r.value  = shadow_stack[shadow_fill];
                    r.status = sm_pkg::ST_RET;
                    popped   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (!popped && shadow_fill > 0)
        begin
            r.value = shadow_stack[shadow_fill - 1];
        end
        r.depth = 5'(shadow_fill);
        return r;
    endfunction

    // Draw an idle gap; now and then start a run of back-to-back beats
    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Q16.16 operand: extremes, zero, small integers, fractions, full range
    function automatic logic [31:0] rand_q();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = sm_pkg::Q_MAX;
            2:       v = sm_pkg::Q_MIN;
            5, 6:    v = ($urandom_range(0, 40) - 20) << 16;
            7:       v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            8:       v = $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            9:
            begin
                v = $urandom_range(0, 65535);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Pick an opcode that keeps programs mostly well formed, with some noise
    function automatic logic [2:0] pick_op(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return 3'($urandom_range(0, 7));
        end
        if (shadow_fill < 2 && r < 75)
        begin
            return sm_pkg::OP_PUSH;
        end
        if (shadow_fill == STACK_SLOTS && r < 50)
        begin
            return 3'($urandom_range(sm_pkg::OP_ADD, sm_pkg::OP_DIV));
        end
        if ($urandom_range(0, 99) < push_pct)
        begin
            return sm_pkg::OP_PUSH;
        end
        r = $urandom_range(0, 99);
        if (r < 22)
        begin
            return sm_pkg::OP_ADD;
        end
        if (r < 44)
        begin
            return sm_pkg::OP_SUB;
        end
        if (r < 64)
        begin
            return sm_pkg::OP_MUL;
        end
        if (r < 80)
        begin
            return sm_pkg::OP_DIV;
        end
        if (r < 90)
        begin
            return sm_pkg::OP_NEG;
        end
        if (r < 98)
        begin
            return sm_pkg::OP_RET;
        end
        return OP_UNUSED;
    endfunction

    // Offer one instruction beat and record the result it owes once accepted
    task automatic send_instr(logic [2:0] op, logic [31:0] k);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.command        <= op;
        cmd_ch.constant_value <= k;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        owed_results.push_back(execute_instr(op, k));
    endtask

    // Compare one result beat against the oldest owed result
    task automatic check_result();
        vm_result_t want;
        if (owed_results.size() == 0)
        begin
            $error("unexpected result beat: status %0d value %h depth %0d",
                   res_ch.status, res_ch.result_value, res_ch.stack_depth);
            error_count++;
        end
        else
        begin
            want = owed_results.pop_front();
            if (res_ch.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, res_ch.status);
                error_count++;
            end
            if (res_ch.result_value !== want.value)
            begin
                $error("result_value: expected %h, got %h", want.value, res_ch.result_value);
                error_count++;
            end
            if (res_ch.stack_depth !== want.depth)
            begin
                $error("stack_depth: expected %0d, got %0d", want.depth, res_ch.stack_depth);
                error_count++;
            end
        end
    endtask

    // Underflow on an empty or short stack, saturation of every operation, divide by zero
    task automatic test_corner_cases();
        send_instr(sm_pkg::OP_RET, $urandom);
        send_instr(sm_pkg::OP_NEG, $urandom);
        send_instr(sm_pkg::OP_PUSH, sm_pkg::Q_MIN);
        send_instr(sm_pkg::OP_SUB, $urandom);
        send_instr(sm_pkg::OP_NEG, $urandom);
        send_instr(sm_pkg::OP_PUSH, sm_pkg::Q_MAX);
        send_instr(sm_pkg::OP_ADD, $urandom);
        send_instr(sm_pkg::OP_PUSH, 32'hFFFF_0000);
        send_instr(sm_pkg::OP_SUB, $urandom);
        send_instr(sm_pkg::OP_PUSH, 32'h0000_0000);
        send_instr(sm_pkg::OP_DIV, $urandom);
        send_instr(OP_UNUSED, $urandom);
        send_instr(sm_pkg::OP_RET, $urandom);
        send_instr(sm_pkg::OP_MUL, $urandom);
        send_instr(sm_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_instr(sm_pkg::OP_DIV, $urandom);
        send_instr(sm_pkg::OP_PUSH, 32'h0001_8000);
        send_instr(sm_pkg::OP_MUL, $urandom);
        send_instr(sm_pkg::OP_PUSH, 32'hFFFF_0000);
        send_instr(sm_pkg::OP_DIV, $urandom);
        send_instr(sm_pkg::OP_PUSH, 32'h0003_0000);
        send_instr(sm_pkg::OP_SUB, $urandom);
        send_instr(sm_pkg::OP_RET, $urandom);
    endtask

    // Fill the stack and overflow it, then negate, multiply, push and return past empty
    task automatic test_fill_and_drain();
        while (shadow_fill > 0)
        begin
            send_instr(sm_pkg::OP_RET, $urandom);
        end
        repeat (STACK_SLOTS) send_instr(sm_pkg::OP_PUSH, rand_q());
        send_instr(sm_pkg::OP_PUSH, rand_q());
        send_instr(sm_pkg::OP_NEG, $urandom);
        send_instr(sm_pkg::OP_MUL, $urandom);
        send_instr(sm_pkg::OP_PUSH, rand_q());
        while (shadow_fill > 0)
        begin
            send_instr(sm_pkg::OP_RET, $urandom);
        end
        send_instr(sm_pkg::OP_RET, $urandom);
    endtask

    // Random programs with random operands
    task automatic test_random_programs(int count, int push_pct);
        logic [2:0] op;
        repeat (count)
        begin
            op = pick_op(push_pct);
            send_instr(op, (op == sm_pkg::OP_PUSH) ? rand_q() : $urandom);
        end
    endtask

    // Hold off the result side for a long stretch while instructions keep coming
    task automatic test_backpressure();
        hold_results = 1'b1;
        test_random_programs(40, 45);
    endtask

    // Result side: random stalls, one long hold on request
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap(recv_calm);
            if (hold_results)
            begin
                hold_results = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            check_result();
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = sm_pkg::OP_PUSH;
        cmd_ch.constant_value = '0;
        shadow_fill           = 0;
        error_count           = 0;
        send_calm             = 0;
        recv_calm             = 0;
        hold_results          = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_fill_and_drain();
        test_random_programs(900, 45);
        test_backpressure();
        test_random_programs(450, 70);
        test_random_programs(400, 45);

        // Drop valid and let every owed result arrive
        cmd_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
